// ----- sv/ttfb_pkg.sv -----
// ----------------------------------------------------------------------------
// ttfb_pkg
// Shared types and constants for the text terminal framebuffer: item kinds,
// control codes, register indexes and the control/status structs.
// ----------------------------------------------------------------------------
package ttfb_pkg;

    typedef enum logic [1:0] {
        K_PUT   = 2'd0,
        K_MOVE  = 2'd1,
        K_CLEAR = 2'd2,
        K_READ  = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        W_INIT   = 2'd0,
        W_CLEAR  = 2'd1,
        W_SCROLL = 2'd2
    } t_walk_mode;

    localparam logic [7:0] CH_BS    = 8'h08;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;

    localparam logic [0:0] REG_FG = 1'b0;
    localparam logic [0:0] REG_BG = 1'b1;

    localparam logic [3:0] FG_RESET = 4'hF;
    localparam logic [3:0] BG_RESET = 4'h0;

    // blank cell as left by reset, independent of later colour writes
    localparam logic [15:0] BLANK_RESET = {BG_RESET, FG_RESET, CH_SPACE};

    typedef struct packed {
        logic       load_in;
        logic       exec_put;
        logic       exec_move;
        logic       exec_clear;
        logic       exec_read;
        logic       walk_start;
        t_walk_mode walk_mode;
        logic       walk_step;
        logic       out_load;
    } t_cmd;

    typedef struct packed {
        t_kind kind;
        logic  need_scroll;
        logic  walk_last;
    } t_stat;

endpackage

// ----- sv/text_terminal_framebuffer.sv -----
// ----------------------------------------------------------------------------
// text_terminal_framebuffer
// Character-cell terminal engine: cursor, colour registers and a text frame
// store with put, move, clear and read items, one result beat per item.
// ----------------------------------------------------------------------------
//  channel   handshake                   payload
//  input     i_in_valid / o_in_ready     i_kind, i_ch, i_col, i_row
//  result    o_out_valid / i_out_ready   o_cursor_col, o_cursor_row,
//                                        o_cursor_address, o_read_entry
//  config    i_cfg_we                    i_cfg_index, i_cfg_data
//
//  put (no scroll), move, read: the result is registered as the item executes,
//  or in S_FINISH once the slot frees; no new item is taken before that.
//  scroll and clear: a walk over all ROWS*COLUMNS cells, one cell a cycle
//  through the frame store's single write port. after reset a clearing pass
//  over all cells runs with o_in_ready low; config writes are taken during it.
//  a result waiting on i_out_ready does not block the next input beat.
// ----------------------------------------------------------------------------
module text_terminal_framebuffer
    import ttfb_pkg::*;
#(
    parameter int COLUMNS  = 80,
    parameter int ROWS     = 25,
    parameter int TAB_STOP = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_kind,
    input  logic [7:0]  i_ch,
    input  logic [6:0]  i_col,
    input  logic [4:0]  i_row,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [6:0]  o_cursor_col,
    output logic [4:0]  o_cursor_row,
    output logic [10:0] o_cursor_address,
    output logic [15:0] o_read_entry,
    input  logic        i_cfg_we,
    input  logic [0:0]  i_cfg_index,
    input  logic [3:0]  i_cfg_data
);

    t_cmd  cmd;
    t_stat stat;

    ttfb_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    ttfb_dpath #(
        .COLUMNS  (COLUMNS),
        .ROWS     (ROWS),
        .TAB_STOP (TAB_STOP)
    ) u_dpath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_stat           (stat),
        .i_kind           (i_kind),
        .i_ch             (i_ch),
        .i_col            (i_col),
        .i_row            (i_row),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .o_cursor_col     (o_cursor_col),
        .o_cursor_row     (o_cursor_row),
        .o_cursor_address (o_cursor_address),
        .o_read_entry     (o_read_entry)
    );

    // result register only reloaded when its beat is gone
    a_out_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.out_load |-> (!o_out_valid || i_out_ready))
        else $error("result reloaded while previous beat still pending");

    // walker owns the write port, no put or new item alongside it
    a_walk_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.walk_step |-> !(cmd.exec_put || cmd.load_in))
        else $error("walk overlaps item handling");

    // walk stops after the last cell
    a_walk_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.walk_step && stat.walk_last) |=> !cmd.walk_step)
        else $error("walk ran past the last cell");

    // an accepted beat is executed in the following cycle
    a_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=>
            (cmd.exec_put || cmd.exec_move || cmd.exec_clear || cmd.exec_read))
        else $error("accepted beat not executed");

endmodule

// ----- sv/ttfb_ram.sv -----
// ----------------------------------------------------------------------------
// ttfb_ram
// Generic simple dual-port RAM: one write port, one read port with
// registered read data.
// ----------------------------------------------------------------------------
module ttfb_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- sv/ttfb_ctrl.sv -----
// ----------------------------------------------------------------------------
// ttfb_ctrl
// Sequencer for the terminal: takes items, steps the datapath through put,
// move, read, clear and scroll, and holds the result slot valid flag.
// ----------------------------------------------------------------------------
module ttfb_ctrl
    import ttfb_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_ready,
    output logic  o_out_valid,
    input  logic  i_out_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    typedef enum logic [2:0] {
        S_INIT,
        S_INIT_DRAIN,
        S_IDLE,
        S_EXEC,
        S_WALK,
        S_DRAIN,
        S_FINISH
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid;
    logic   slot_ok;

    // result slot can take a beat if empty or emptied this cycle
    assign slot_ok    = !r_out_valid || i_out_ready;
    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_cmd.walk_mode = W_INIT;
        case (r_state)
            S_INIT: begin
                o_cmd.walk_step = 1'b1;
                if (i_stat.walk_last) begin
                    n_state = S_INIT_DRAIN;
                end
            end
            S_INIT_DRAIN: begin
                n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state       = S_EXEC;
                end
            end
            S_EXEC: begin
                case (i_stat.kind)
                    K_PUT: begin
                        o_cmd.exec_put = 1'b1;
                        if (i_stat.need_scroll) begin
                            o_cmd.walk_start = 1'b1;
                            o_cmd.walk_mode  = W_SCROLL;
                            n_state          = S_WALK;
                        end else if (slot_ok) begin
                            o_cmd.out_load = 1'b1;
                            n_state        = S_IDLE;
                        end else begin
                            n_state = S_FINISH;
                        end
                    end
                    K_MOVE: begin
                        o_cmd.exec_move = 1'b1;
                        if (slot_ok) begin
                            o_cmd.out_load = 1'b1;
                            n_state        = S_IDLE;
                        end else begin
                            n_state = S_FINISH;
                        end
                    end
                    K_CLEAR: begin
                        o_cmd.exec_clear = 1'b1;
                        o_cmd.walk_start = 1'b1;
                        o_cmd.walk_mode  = W_CLEAR;
                        n_state          = S_WALK;
                    end
                    K_READ: begin
                        o_cmd.exec_read = 1'b1;
                        if (slot_ok) begin
                            o_cmd.out_load = 1'b1;
                            n_state        = S_IDLE;
                        end else begin
                            n_state = S_FINISH;
                        end
                    end
                    default: begin
                        n_state = S_IDLE;
                    end
                endcase
            end
            S_WALK: begin
                o_cmd.walk_step = 1'b1;
                if (i_stat.walk_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_state = S_FINISH;
            end
            S_FINISH: begin
                if (slot_ok) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

// ----- sv/ttfb_dpath.sv -----
// ----------------------------------------------------------------------------
// ttfb_dpath
// Datapath for the terminal: cursor, colour registers, frame store, the
// screen walker for clear and scroll, and the result register.
// ----------------------------------------------------------------------------
module ttfb_dpath
    import ttfb_pkg::*;
#(
    parameter int COLUMNS  = 80,
    parameter int ROWS     = 25,
    parameter int TAB_STOP = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    output t_stat       o_stat,
    input  logic [1:0]  i_kind,
    input  logic [7:0]  i_ch,
    input  logic [6:0]  i_col,
    input  logic [4:0]  i_row,
    input  logic        i_cfg_we,
    input  logic [0:0]  i_cfg_index,
    input  logic [3:0]  i_cfg_data,
    output logic [6:0]  o_cursor_col,
    output logic [4:0]  o_cursor_row,
    output logic [10:0] o_cursor_address,
    output logic [15:0] o_read_entry
);

    localparam int CW    = $clog2(COLUMNS);
    localparam int RW    = $clog2(ROWS);
    localparam int CELLS = COLUMNS * ROWS;
    localparam int AW    = $clog2(CELLS);

    // captured item
    t_kind      r_kind;
    logic [7:0] r_ch;
    logic [6:0] r_col_in;
    logic [4:0] r_row_in;

    logic [3:0] r_fg, r_bg;

    logic [CW-1:0] r_cur_col, n_cur_col;
    logic [RW-1:0] r_cur_row, n_cur_row;

    // screen walker and its write stage
    logic [AW-1:0] r_walk;
    t_walk_mode    r_mode;
    logic          r_wp_valid;
    logic [AW-1:0] r_wp_addr;
    logic          r_wp_copy;

    logic [15:0] r_entry, entry_now;

    // put-byte decode
    logic [CW-1:0] put_col;
    logic [RW-1:0] put_row;
    logic          put_inc;
    logic          put_scroll;
    logic          printable;

    logic [CW:0]   tab_rom [2**CW];
    logic [CW:0]   tab_ent;

    logic [CW-1:0] mv_col;
    logic [RW-1:0] mv_row;
    logic          rd_in_range;

    logic [AW-1:0] cur_addr, in_addr, rd_src, n_addr;
    logic [AW-1:0] ram_raddr, ram_waddr;
    logic [15:0]   ram_wdata, ram_rdata, blank;
    logic          ram_we;

    // next tab stop per column; top bit marks a wrap to the next row
    for (genvar g = 0; g < 2**CW; g++) begin : g_tab
        localparam int NX = (g / TAB_STOP + 1) * TAB_STOP;
        if (g < COLUMNS && NX < COLUMNS) begin : g_in
            assign tab_rom[g] = {1'b0, CW'(NX)};
        end else begin : g_wrap
            assign tab_rom[g] = {1'b1, CW'(0)};
        end
    end
    assign tab_ent = tab_rom[r_cur_col];

    always_comb begin
        put_col   = r_cur_col;
        put_row   = r_cur_row;
        put_inc   = 1'b0;
        printable = 1'b0;
        case (r_ch)
            CH_TAB: begin
                if (tab_ent[CW]) begin
                    put_col = '0;
                    put_inc = 1'b1;
                end else begin
                    put_col = tab_ent[CW-1:0];
                end
            end
            CH_LF: begin
                put_col = '0;
                put_inc = 1'b1;
            end
            CH_CR: begin
                put_col = '0;
            end
            CH_BS: begin
                if (r_cur_col == '0) begin
                    if (r_cur_row != '0) begin
                        put_row = r_cur_row - RW'(1);
                        put_col = CW'(COLUMNS - 1);
                    end
                end else begin
                    put_col = r_cur_col - CW'(1);
                end
            end
            default: begin
                printable = 1'b1;
                if (r_cur_col == CW'(COLUMNS - 1)) begin
                    put_col = '0;
                    put_inc = 1'b1;
                end else begin
                    put_col = r_cur_col + CW'(1);
                end
            end
        endcase
        put_scroll = 1'b0;
        if (put_inc) begin
            // past the last row the screen scrolls and the cursor stays there
            if (r_cur_row == RW'(ROWS - 1)) begin
                put_scroll = 1'b1;
            end else begin
                put_row = r_cur_row + RW'(1);
            end
        end
    end

    assign mv_col      = (r_col_in < COLUMNS) ? CW'(r_col_in) : CW'(COLUMNS - 1);
    assign mv_row      = (r_row_in < ROWS) ? RW'(r_row_in) : RW'(ROWS - 1);
    assign rd_in_range = (r_col_in < COLUMNS) && (r_row_in < ROWS);

    always_comb begin
        n_cur_col = r_cur_col;
        n_cur_row = r_cur_row;
        if (i_cmd.exec_put) begin
            n_cur_col = put_col;
            n_cur_row = put_row;
        end else if (i_cmd.exec_move) begin
            n_cur_col = mv_col;
            n_cur_row = mv_row;
        end else if (i_cmd.exec_clear) begin
            n_cur_col = '0;
            n_cur_row = '0;
        end
    end

    always_comb begin
        if (i_cmd.exec_read) begin
            entry_now = rd_in_range ? ram_rdata : 16'h0000;
        end else if (i_cmd.exec_put || i_cmd.exec_move || i_cmd.exec_clear) begin
            entry_now = 16'h0000;
        end else begin
            entry_now = r_entry;
        end
    end

    assign cur_addr = AW'(r_cur_row) * AW'(COLUMNS) + AW'(r_cur_col);
    assign n_addr   = AW'(n_cur_row) * AW'(COLUMNS) + AW'(n_cur_col);
    // read is issued while the item is offered so data is there in the next cycle
    assign in_addr  = AW'(i_row) * AW'(COLUMNS) + AW'(i_col);
    assign rd_src   = r_walk + AW'(COLUMNS);

    assign blank = (r_mode == W_INIT) ? BLANK_RESET : {r_bg, r_fg, CH_SPACE};

    assign ram_raddr = i_cmd.walk_step ? rd_src : in_addr;
    assign ram_we    = r_wp_valid || (i_cmd.exec_put && printable);
    assign ram_waddr = r_wp_valid ? r_wp_addr : cur_addr;
    always_comb begin
        if (r_wp_valid) begin
            ram_wdata = r_wp_copy ? ram_rdata : blank;
        end else begin
            ram_wdata = {r_bg, r_fg, r_ch};
        end
    end

    ttfb_ram #(
        .WIDTH (16),
        .DEPTH (CELLS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fg       <= FG_RESET;
            r_bg       <= BG_RESET;
            r_cur_col  <= '0;
            r_cur_row  <= '0;
            r_walk     <= '0;
            r_mode     <= W_INIT;
            r_wp_valid <= 1'b0;
            r_entry    <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_FG:  r_fg <= i_cfg_data;
                    REG_BG:  r_bg <= i_cfg_data;
                    default: ;
                endcase
            end
            r_cur_col <= n_cur_col;
            r_cur_row <= n_cur_row;
            r_entry   <= entry_now;
            if (i_cmd.walk_start) begin
                r_mode <= i_cmd.walk_mode;
            end
            r_wp_valid <= i_cmd.walk_step;
            if (i_cmd.walk_step) begin
                r_walk <= (r_walk == AW'(CELLS - 1)) ? '0 : r_walk + AW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_kind   <= t_kind'(i_kind);
            r_ch     <= i_ch;
            r_col_in <= i_col;
            r_row_in <= i_row;
        end
        if (i_cmd.walk_step) begin
            r_wp_addr <= r_walk;
            // scroll copies row below, last row gets blanks
            r_wp_copy <= (r_mode == W_SCROLL) && (r_walk < AW'(CELLS - COLUMNS));
        end
        if (i_cmd.out_load) begin
            o_cursor_col     <= 7'(n_cur_col);
            o_cursor_row     <= 5'(n_cur_row);
            o_cursor_address <= 11'(n_addr);
            o_read_entry     <= entry_now;
        end
    end

    assign o_stat.kind        = r_kind;
    assign o_stat.need_scroll = put_scroll;
    assign o_stat.walk_last   = (r_walk == AW'(CELLS - 1));

endmodule
